// ===== design/fbs_pkg.sv =====
package fbs_pkg;

  localparam int unsigned IN_TIME_W      = 16;
  localparam int unsigned ID_W           = 5;
  localparam int unsigned TICK_W         = 21;
  localparam int unsigned SUM_W          = 25;
  localparam int unsigned MAX_PROCS_DEF  = 16;
  localparam int unsigned TIME_BITS_DEF  = 16;

  typedef struct packed {
    logic [IN_TIME_W-1:0] arrival_time;
    logic [IN_TIME_W-1:0] burst_length;
    logic                 batch_end;
  } in_beat_t;

  typedef struct packed {
    logic [ID_W-1:0]   process_id;
    logic [TICK_W-1:0] start_tick;
    logic [TICK_W-1:0] finish_tick;
    logic [TICK_W-1:0] wait_ticks;
    logic [TICK_W-1:0] turnaround_ticks;
    logic [SUM_W-1:0]  sum_wait;
    logic [SUM_W-1:0]  sum_turnaround;
    logic              final_result;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } fbs_state_e;

  typedef struct packed {
    logic insert;
    logic issue;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic one_left;
    logic a_free;
  } dp_stat_t;

endpackage

// ===== design/fbs_if.sv =====
interface fbs_in_if ();
  logic               valid;
  logic               ready;
  fbs_pkg::in_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fbs_out_if ();
  logic               valid;
  logic               ready;
  fbs_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/fbs_ctrl.sv =====
module fbs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  input  fbs_pkg::dp_stat_t   stat_i,
  output logic                in_ready_o,
  output fbs_pkg::ctrl_cmd_t  cmd_o
);
  import fbs_pkg::*;

  fbs_state_e state_q, state_d;
  logic       accept;

  always_comb begin
    in_ready_o   = (state_q == ST_LOAD);
    accept       = in_valid_i && in_ready_o;
    // A beat that finds the store full is dropped, but it can still close the batch.
    cmd_o.insert = accept && !stat_i.full;
    cmd_o.issue  = (state_q == ST_EMIT) && stat_i.a_free;
    state_d      = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept && in_last_i) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.issue && stat_i.one_left) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/fbs_dp.sv =====
module fbs_dp #(
  parameter int unsigned MAX_PROCS = fbs_pkg::MAX_PROCS_DEF,
  parameter int unsigned TIME_BITS = fbs_pkg::TIME_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fbs_pkg::ctrl_cmd_t  cmd_i,
  input  fbs_pkg::in_beat_t   in_data_i,
  output fbs_pkg::dp_stat_t   stat_o,
  fbs_out_if.source           out_o
);
  import fbs_pkg::*;

  localparam int unsigned TW    = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
  localparam int unsigned CLK_W = TW + CNT_W;

  typedef struct packed {
    logic [TW-1:0]    arr;
    logic [TW-1:0]    bur;
    logic [CNT_W-1:0] pid;
  } cell_t;

  // Sorted cell array: entry 0 always holds the earliest arrival.
  cell_t            cell_q  [MAX_PROCS];
  cell_t            up_cell [MAX_PROCS];
  cell_t            dn_cell [MAX_PROCS];
  logic             gt      [MAX_PROCS];
  logic             ins     [MAX_PROCS];
  logic             up_ins  [MAX_PROCS];
  cell_t            new_cell;
  logic [CNT_W-1:0] count_q, count_d;

  // Issue stage.
  logic [CLK_W-1:0] clock_q, clock_d;
  logic [CLK_W-1:0] head_arr, start_t, finish_t;
  logic             a_valid_q, a_valid_d;
  logic [CLK_W-1:0] a_start_q, a_finish_q, a_arr_q;
  logic [CNT_W-1:0] a_pid_q;
  logic             a_last_q;

  // Result stage.
  logic             out_free, b_load;
  logic             ov_q, ov_d;
  logic [SUM_W-1:0] acc_w_q, acc_w_d, acc_t_q, acc_t_d;
  out_beat_t        ob_q;

  always_comb begin
    new_cell.arr = in_data_i.arrival_time[TW-1:0];
    new_cell.bur = in_data_i.burst_length[TW-1:0];
    new_cell.pid = count_q + CNT_W'(1);
    for (int k = 0; k < MAX_PROCS; k++) begin
      gt[k]  = (CNT_W'(k) < count_q) && (cell_q[k].arr > new_cell.arr);
      ins[k] = (CNT_W'(k) < count_q) ? gt[k] : (CNT_W'(k) == count_q);
    end
  end

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign up_ins[g]  = 1'b0;
      assign up_cell[g] = new_cell;
    end else begin : g_body
      assign up_ins[g]  = ins[g-1];
      assign up_cell[g] = cell_q[g-1];
    end
    if (g == MAX_PROCS - 1) begin : g_tail
      assign dn_cell[g] = cell_q[g];
    end else begin : g_inner
      assign dn_cell[g] = cell_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert && ins[g]) begin
        cell_q[g] <= up_ins[g] ? up_cell[g] : new_cell;
      end else if (cmd_i.issue) begin
        cell_q[g] <= dn_cell[g];
      end
    end
  end

  always_comb begin
    stat_o.full     = (count_q == CNT_W'(MAX_PROCS));
    stat_o.one_left = (count_q == CNT_W'(1));

    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.issue) begin
      count_d = count_q - CNT_W'(1);
    end

    // The time counter idles forward to the arrival when it is ahead of now.
    head_arr = CLK_W'(cell_q[0].arr);
    start_t  = (clock_q < head_arr) ? head_arr : clock_q;
    finish_t = start_t + CLK_W'(cell_q[0].bur);
    clock_d  = clock_q;
    if (cmd_i.issue) begin
      clock_d = stat_o.one_left ? '0 : finish_t;
    end

    out_free  = !ov_q || out_o.ready;
    b_load    = a_valid_q && out_free;
    a_valid_d = cmd_i.issue || (a_valid_q && !b_load);
    ov_d      = b_load || (ov_q && !out_o.ready);

    acc_w_d = acc_w_q + SUM_W'(a_start_q) - SUM_W'(a_arr_q);
    acc_t_d = acc_t_q + SUM_W'(a_finish_q) - SUM_W'(a_arr_q);

    stat_o.a_free   = !a_valid_q || b_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      clock_q   <= '0;
      a_valid_q <= 1'b0;
      ov_q      <= 1'b0;
      acc_w_q   <= '0;
      acc_t_q   <= '0;
    end else begin
      count_q   <= count_d;
      clock_q   <= clock_d;
      a_valid_q <= a_valid_d;
      ov_q      <= ov_d;
      if (b_load) begin
        acc_w_q <= a_last_q ? '0 : acc_w_d;
        acc_t_q <= a_last_q ? '0 : acc_t_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      a_start_q  <= start_t;
      a_finish_q <= finish_t;
      a_arr_q    <= head_arr;
      a_pid_q    <= cell_q[0].pid;
      a_last_q   <= stat_o.one_left;
    end
    if (b_load) begin
      ob_q.process_id       <= ID_W'(a_pid_q);
      ob_q.start_tick       <= TICK_W'(a_start_q);
      ob_q.finish_tick      <= TICK_W'(a_finish_q);
      ob_q.wait_ticks       <= TICK_W'(a_start_q - a_arr_q);
      ob_q.turnaround_ticks <= TICK_W'(a_finish_q - a_arr_q);
      ob_q.sum_wait         <= a_last_q ? acc_w_d : '0;
      ob_q.sum_turnaround   <= a_last_q ? acc_t_d : '0;
      ob_q.final_result     <= a_last_q;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = ob_q;

endmodule

// ===== design/fcfs_batch_scheduler.sv =====
// Channel  Dir  Beat                                      Accepted when
// in_i     in   arrival, burst, batch_end                 valid && ready
// out_o    out  id, start, finish, wait, turnaround, sums valid && ready
//
// Each loading beat is inserted into the sorted cell array, or dropped if full.
// After the beat that closes a batch, the input is held off while one process
// a cycle leaves the head of the array, unless a stalled output holds issue; the
// clock-advance step (compare, select, add) in the issue stage sets that rate.
// The first result goes through the issue and result stages; a stalled output
// stops issue once the issue and result stages are both full. Reset clears
// control state, counters and totals only; the cell contents need no clearing.
module fcfs_batch_scheduler #(
  parameter int unsigned MAX_PROCS = fbs_pkg::MAX_PROCS_DEF,
  parameter int unsigned TIME_BITS = fbs_pkg::TIME_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fbs_in_if.sink     in_i,
  fbs_out_if.source  out_o
);
  import fbs_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  fbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.data.batch_end),
    .stat_i     (stat),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  fbs_dp #(
    .MAX_PROCS (MAX_PROCS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_i.data),
    .stat_o    (stat),
    .out_o     (out_o)
  );

`ifndef SYNTHESIS
  a_close_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.data.batch_end) |=> !in_i.ready)
    else $error("input still open after the closing beat");

  a_issue_not_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> (!cmd.insert && !in_i.ready))
    else $error("issue overlaps loading");

  a_sums_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.final_result) |->
      (out_o.data.sum_wait == '0 && out_o.data.sum_turnaround == '0))
    else $error("totals on a result that is not final");
`endif

endmodule
